[rtl/rgbpi_pkg.sv]
// Package for the RGB565 palette indexer: command codes, palette sizing,
// colour masks and the structs shared by the engine and the top level.
// No dependencies.
`timescale 1ns / 1ps

package rgbpi_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  localparam logic [15:0] RED_MASK   = 16'hf800;
  localparam logic [15:0] GREEN_MASK = 16'h07e0;
  localparam logic [15:0] BLUE_MASK  = 16'h001f;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LEARN = 2'd1,
    CMD_MAP   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [8:0] color_count;
    logic       full_res;
    logic       added;
    logic       found;
    logic [7:0] index;
    logic       pass_end;
  } res_t;

endpackage

[rtl/rgb565_palette_indexer_top.sv]
// Top level of the RGB565 palette indexer: stream ports, palette memory,
// command engine and output word register.
// Depends on rgbpi_pkg, rgbpi_ram and rgbpi_engine.
`timescale 1ns / 1ps

// One command word is worked on at a time. Clear goes straight to its
// result; read first waits for the registered read data, unless the entry
// lies at or beyond the stored count. Learn and map walk the palette memory
// one entry per cycle from entry 0 and stop at the first match or after the
// last stored colour; the single read port of the palette memory sets that
// rate. The result word appears on out_tvalid in the cycle in which the
// engine is ready again, and a new word is taken while that result still
// waits in the output register; if the register is still held when the next
// result is ready, the engine waits. The palette memory needs no clearing
// pass: only entries below the stored count are ever read, and the memory is
// never read and written at the same entry in one command.
module rgb565_palette_indexer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel[15:0], entry_index[23:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  // index[7:0], found[8], added[9], full_res[10], color_count[19:11],
  // red[27:20], green[35:28], blue[43:36], zero[47:44]
  output logic [47:0] out_tdata,
  output logic        out_tlast   // pass_end
);

  rgbpi_pkg::ram_req_t ram_req;
  rgbpi_pkg::res_t     res;
  rgbpi_pkg::res_t     out_r;
  logic [15:0]         ram_rd_data;
  logic                res_valid;
  logic                res_take;
  logic                out_valid_r;

  rgbpi_ram #(
    .WIDTH(16),
    .DEPTH(rgbpi_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (ram_req.wr_en),
    .wr_addr(ram_req.wr_addr),
    .wr_data(ram_req.wr_data),
    .rd_en  (ram_req.rd_en),
    .rd_addr(ram_req.rd_addr),
    .rd_data(ram_rd_data)
  );

  rgbpi_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_command    (in_tuser),
    .in_pixel      (in_tdata[15:0]),
    .in_entry_index(in_tdata[23:16]),
    .in_last_pixel (in_tlast),
    .ram_req       (ram_req),
    .ram_rd_data   (ram_rd_data),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  // The output register loads a waiting result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.pass_end;
  assign out_tdata  = {4'b0000, out_r.blue, out_r.green, out_r.red, out_r.color_count,
                       out_r.full_res, out_r.added, out_r.found, out_r.index};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("engine took a second word while busy");

  a_added_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9]) |-> out_tdata[8])
    else $error("colour appended without being reported as found");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10] == (32'(out_tdata[19:11]) == rgbpi_pkg::PALETTE_DEPTH)))
    else $error("full flag disagrees with colour count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[19:11]) <= rgbpi_pkg::PALETTE_DEPTH))
    else $error("colour count beyond palette depth");

endmodule

[rtl/rgbpi_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module rgbpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rgbpi_engine.sv]
// Command sequencer of the palette indexer: walks the palette memory one
// entry a cycle for learn and map, appends new colours and expands reads.
// Depends on rgbpi_pkg.
`timescale 1ns / 1ps

module rgbpi_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [15:0]               in_pixel,
  input  logic [7:0]                in_entry_index,
  input  logic                      in_last_pixel,
  output rgbpi_pkg::ram_req_t       ram_req,
  input  logic [15:0]               ram_rd_data,
  output logic                      res_valid,
  input  logic                      res_take,
  output rgbpi_pkg::res_t           res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  state_t                         state_r;
  logic [rgbpi_pkg::CNT_W-1:0]    count_r;
  logic [rgbpi_pkg::ADDR_W-1:0]   k_r;
  logic                           empty_r;
  rgbpi_pkg::cmd_t                cmd_r;
  logic [15:0]                    pixel_r;
  rgbpi_pkg::res_t                res_r;
  rgbpi_pkg::res_t                res_init;

  logic accept;
  logic scan_hit;
  logic scan_end;
  logic can_append;
  logic entry_ok;

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    accept     = in_valid && in_ready;
    // An empty palette still passes through the scan state, with the stale
    // read data masked off.
    scan_hit   = !empty_r && (ram_rd_data == pixel_r);
    scan_end   = empty_r ||
                 ((rgbpi_pkg::CNT_W'(k_r) + rgbpi_pkg::CNT_W'(1)) == count_r);
    can_append = (32'(count_r) < rgbpi_pkg::PALETTE_DEPTH);
    entry_ok   = (32'(in_entry_index) < 32'(count_r)) &&
                 (32'(in_entry_index) < rgbpi_pkg::PALETTE_DEPTH);

    // Result word as it starts out when a command is taken.
    res_init          = '0;
    res_init.pass_end = in_last_pixel;
    if (rgbpi_pkg::cmd_t'(in_command) == rgbpi_pkg::CMD_READ) begin
      res_init.index = in_entry_index;
    end

    ram_req         = '0;
    ram_req.wr_addr = count_r[rgbpi_pkg::ADDR_W-1:0];
    ram_req.wr_data = pixel_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (rgbpi_pkg::cmd_t'(in_command) == rgbpi_pkg::CMD_READ) begin
            ram_req.rd_en   = entry_ok;
            ram_req.rd_addr = rgbpi_pkg::ADDR_W'(in_entry_index);
          end else if (rgbpi_pkg::cmd_t'(in_command) != rgbpi_pkg::CMD_CLEAR) begin
            ram_req.rd_en   = (count_r != '0);
            ram_req.rd_addr = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_hit && !scan_end) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = k_r + rgbpi_pkg::ADDR_W'(1);
        end
        if (!scan_hit && scan_end && cmd_r == rgbpi_pkg::CMD_LEARN && can_append) begin
          ram_req.wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_valid       = (state_r == ST_DONE);
    res             = res_r;
    res.color_count = 9'(count_r);
    res.full_res    = (32'(count_r) == rgbpi_pkg::PALETTE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= rgbpi_pkg::cmd_t'(in_command);
            pixel_r <= in_pixel;
            k_r     <= '0;
            empty_r <= (count_r == '0);
            res_r   <= res_init;
            unique case (rgbpi_pkg::cmd_t'(in_command))
              rgbpi_pkg::CMD_CLEAR: begin
                count_r <= '0;
                state_r <= ST_DONE;
              end
              rgbpi_pkg::CMD_LEARN, rgbpi_pkg::CMD_MAP: begin
                state_r <= ST_SCAN;
              end
              rgbpi_pkg::CMD_READ: begin
                state_r <= entry_ok ? ST_RDWAIT : ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            res_r.index <= 8'(k_r);
            res_r.found <= 1'b1;
            state_r     <= ST_DONE;
          end else if (scan_end) begin
            if (cmd_r == rgbpi_pkg::CMD_LEARN && can_append) begin
              count_r     <= count_r + rgbpi_pkg::CNT_W'(1);
              res_r.index <= 8'(count_r);
              res_r.found <= 1'b1;
              res_r.added <= 1'b1;
            end
            state_r <= ST_DONE;
          end else begin
            k_r <= k_r + rgbpi_pkg::ADDR_W'(1);
          end
        end
        ST_RDWAIT: begin
          res_r.found <= 1'b1;
          res_r.red   <= 8'((ram_rd_data & rgbpi_pkg::RED_MASK) >> 8);
          res_r.green <= 8'((ram_rd_data & rgbpi_pkg::GREEN_MASK) >> 3);
          res_r.blue  <= 8'((ram_rd_data & rgbpi_pkg::BLUE_MASK) << 3);
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
